// ===== src/greedy_overlap_merge_order_assert.svh =====
// assertion macros for the greedy overlap merge order block
// expects clk and rst_n in the scope of the using module
`ifndef GREEDY_OVERLAP_MERGE_ORDER_ASSERT_SVH
`define GREEDY_OVERLAP_MERGE_ORDER_ASSERT_SVH
// antecedent holds, consequent holds in the same cycle
`define GOMO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gomo assertion failed");
// antecedent holds, consequent holds in the next cycle
`define GOMO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gomo assertion failed");
`endif

// ===== src/gomo_pkg.sv =====
// shared types and codes for the greedy overlap merge order block
// no dependencies
`default_nettype none
package gomo_pkg;
    localparam int CMD_W = 2;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_W = 6;
    localparam int TOTAL_W = 14;
    localparam int PLACE_W = 13;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_NEXT  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD,
        ST_CMP,
        ST_PUT
    } state_t;
endpackage
`default_nettype wire

// ===== src/greedy_overlap_merge_order.sv =====
// greedy overlap merge order: record byte store and greedy pick sequencer
// depends on gomo_pkg and greedy_overlap_merge_order_assert.svh
//
// usage: the s_ channel carries commands in s_tuser (load, next, clear); a load
// writes one record byte and marks the slot present, a clear drops all marks
// and the running byte count. each next transaction yields one m_ transaction:
// m_tuser is found, m_tdata the picked slot, placement offset and overlap.
// cfg_we/cfg_wdata set the record length; the user must write it only while the
// block is idle, the block itself does not enforce this. loads, clears and nops
// stay in idle. a next walks all MAX_RECORDS slots in order; for an eligible
// slot, once a pick has been made, it tries overlap lengths from the record
// length down while they beat the best so far, each byte comparison a memory
// read state, then a compare state, over two registered memory read ports.
// the result sits in an output register; while the receiver stalls, loads
// and clears are still taken, a further next waits until the register frees.
// reset clears the present and used marks, last pick and byte count; record
// bytes are kept until written and need no clearing pass.
`include "greedy_overlap_merge_order_assert.svh"
`default_nettype none
module greedy_overlap_merge_order #(
    parameter int MAX_RECORDS = 256,
    parameter int MAX_RECORD_BYTES = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // slot, byte_pos, byte_value, zero pad
    input  wire logic [gomo_pkg::IN_DATA_W-1:0]   s_tdata,
    // cmd
    input  wire logic [gomo_pkg::CMD_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // picked_slot, place, overlap_len, zero pad
    output logic [gomo_pkg::OUT_DATA_W-1:0]       m_tdata,
    // found
    output logic                                  m_tuser,
    input  wire logic                             cfg_we,
    input  wire logic [gomo_pkg::CFG_W-1:0]       cfg_wdata
);
    import gomo_pkg::*;

    localparam int SW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = SW + 1;
    localparam int OW = $clog2(MAX_RECORD_BYTES + 1);
    localparam int DEPTH = MAX_RECORDS * MAX_RECORD_BYTES;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    state_t state_reg, state_next;
    logic [CFG_W-1:0] cfg_reg;
    logic [MAX_RECORDS-1:0] present_reg, present_next;
    logic [MAX_RECORDS-1:0] used_reg, used_next;
    logic [SW-1:0] last_reg, last_next;
    logic last_valid_reg, last_valid_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [SW-1:0] best_reg, best_next;
    logic [OW-1:0] best_ov_reg, best_ov_next;
    logic have_reg, have_next;
    logic [OW-1:0] ov_reg, ov_next;
    logic [OW-1:0] k_reg, k_next;
    logic out_valid_reg, out_valid_next;
    logic out_found_reg, out_found_next;
    logic [7:0] out_slot_reg, out_slot_next;
    logic [PLACE_W-1:0] out_place_reg, out_place_next;
    logic [5:0] out_ov_reg, out_ov_next;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_a_reg, rd_b_reg;
    logic [AW-1:0] addr_a, addr_b, addr_w;
    logic wr_en;

    cmd_t in_cmd;
    logic [7:0] in_slot;
    logic [4:0] in_pos;
    logic [7:0] in_byte;
    logic in_fire, load_ok, scan_done, eligible, out_free;
    logic [SW-1:0] cur;
    logic [OW-1:0] rec;

    assign in_cmd = cmd_t'(s_tuser);
    assign in_slot = s_tdata[7:0];
    assign in_pos = s_tdata[12:8];
    assign in_byte = s_tdata[20:13];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire = s_tvalid && s_tready;
    assign load_ok = (int'(in_slot) < MAX_RECORDS) && (int'(in_pos) < MAX_RECORD_BYTES);
    assign cur = idx_reg[SW-1:0];
    assign scan_done = (int'(idx_reg) >= MAX_RECORDS);
    assign eligible = present_reg[cur] && !used_reg[cur];
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        if (cfg_reg == '0)
            rec = OW'(1);
        else if (int'(cfg_reg) > MAX_RECORD_BYTES)
            rec = OW'(MAX_RECORD_BYTES);
        else
            rec = OW'(cfg_reg);
    end

    assign addr_a = AW'(AW'(last_reg) * AW'(MAX_RECORD_BYTES)) + AW'(rec - ov_reg + k_reg);
    assign addr_b = AW'(AW'(cur) * AW'(MAX_RECORD_BYTES)) + AW'(k_reg);
    assign addr_w = AW'(AW'(SW'(in_slot)) * AW'(MAX_RECORD_BYTES)) + AW'(in_pos);
    assign wr_en = in_fire && (in_cmd == CMD_LOAD) && load_ok;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr_w] <= in_byte;
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_cmd == CMD_NEXT)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                    state_next = ST_PUT;
                else if (eligible && last_valid_reg && rec > best_ov_reg)
                    state_next = ST_RD;
            end
            ST_RD:
                state_next = ST_CMP;
            ST_CMP:
            begin
                if (rd_a_reg == rd_b_reg)
                    state_next = (k_reg + OW'(1) == ov_reg) ? ST_SCAN : ST_RD;
                else
                    state_next = (ov_reg - OW'(1) > best_ov_reg) ? ST_RD : ST_SCAN;
            end
            ST_PUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        present_next = present_reg;
        used_next = used_reg;
        last_next = last_reg;
        last_valid_next = last_valid_reg;
        total_next = total_reg;
        idx_next = idx_reg;
        best_next = best_reg;
        best_ov_next = best_ov_reg;
        have_next = have_reg;
        ov_next = ov_reg;
        k_next = k_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_found_next = out_found_reg;
        out_slot_next = out_slot_reg;
        out_place_next = out_place_reg;
        out_ov_next = out_ov_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (in_cmd)
                        CMD_LOAD:
                        begin
                            if (load_ok)
                                present_next[SW'(in_slot)] = 1'b1;
                        end
                        CMD_NEXT:
                        begin
                            idx_next = '0;
                            best_next = '0;
                            best_ov_next = '0;
                            have_next = 1'b0;
                        end
                        CMD_CLEAR:
                        begin
                            present_next = '0;
                            used_next = '0;
                            last_next = '0;
                            last_valid_next = 1'b0;
                            total_next = '0;
                        end
                        CMD_NOP:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!scan_done)
                begin
                    if (eligible)
                    begin
                        if (best_ov_reg == '0)
                        begin
                            best_next = cur;
                            have_next = 1'b1;
                        end
                        if (last_valid_reg && rec > best_ov_reg)
                        begin
                            ov_next = rec;
                            k_next = '0;
                        end
                        else
                            idx_next = idx_reg + CW'(1);
                    end
                    else
                        idx_next = idx_reg + CW'(1);
                end
            end
            ST_RD:
            begin
            end
            ST_CMP:
            begin
                if (rd_a_reg == rd_b_reg)
                begin
                    if (k_reg + OW'(1) == ov_reg)
                    begin
                        best_next = cur;
                        best_ov_next = ov_reg;
                        idx_next = idx_reg + CW'(1);
                    end
                    else
                        k_next = k_reg + OW'(1);
                end
                else if (ov_reg - OW'(1) > best_ov_reg)
                begin
                    ov_next = ov_reg - OW'(1);
                    k_next = '0;
                end
                else
                    idx_next = idx_reg + CW'(1);
            end
            ST_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (have_reg)
                    begin
                        out_found_next = 1'b1;
                        out_slot_next = 8'(best_reg);
                        out_place_next = PLACE_W'(total_reg - TOTAL_W'(best_ov_reg));
                        out_ov_next = 6'(best_ov_reg);
                        total_next = total_reg + TOTAL_W'(rec) - TOTAL_W'(best_ov_reg);
                        used_next[best_reg] = 1'b1;
                        last_next = best_reg;
                        last_valid_next = 1'b1;
                    end
                    else
                    begin
                        out_found_next = 1'b0;
                        out_slot_next = '0;
                        out_place_next = '0;
                        out_ov_next = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cfg_reg <= CFG_W'(1);
            present_reg <= '0;
            used_reg <= '0;
            last_reg <= '0;
            last_valid_reg <= 1'b0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                cfg_reg <= cfg_wdata;
            present_reg <= present_next;
            used_reg <= used_next;
            last_reg <= last_next;
            last_valid_reg <= last_valid_next;
            total_reg <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        best_reg <= best_next;
        best_ov_reg <= best_ov_next;
        have_reg <= have_next;
        ov_reg <= ov_next;
        k_reg <= k_next;
        out_found_reg <= out_found_next;
        out_slot_reg <= out_slot_next;
        out_place_reg <= out_place_next;
        out_ov_reg <= out_ov_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser = out_found_reg;
    assign m_tdata = {5'd0, out_ov_reg, out_place_reg, out_slot_reg};

    `GOMO_ASSERT_NEXT(a_rd_then_cmp, state_reg == ST_RD, state_reg == ST_CMP)
    `GOMO_ASSERT_NOW(a_cmp_k_below_ov, state_reg == ST_CMP, k_reg < ov_reg && ov_reg > best_ov_reg)
    `GOMO_ASSERT_NOW(a_ov_within_rec, m_tvalid && m_tuser, int'(m_tdata[26:21]) <= int'(rec) || OW > 6)
    `GOMO_ASSERT_NOW(a_not_found_zero, m_tvalid && !m_tuser, m_tdata == '0)
    `GOMO_ASSERT_NEXT(a_pick_marks_used, state_reg == ST_PUT && out_free && have_reg, used_reg[$past(best_reg)] && last_valid_reg)
endmodule
`default_nettype wire

// ===== test/greedy_overlap_merge_order_test.sv =====
// self-checking testbench for greedy_overlap_merge_order: loads records, issues picks
// and checks every pick against a scoreboard that predicts the greedy choice
// depends on gomo_pkg and greedy_overlap_merge_order
`default_nettype none
module greedy_overlap_merge_order_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gomo_pkg::*;

    typedef struct packed {
        logic        found;
        logic [7:0]  slot;
        logic [12:0] place;
        logic [5:0]  overlap;
    } pick_t;

    class merge_order_scoreboard;
        logic [7:0]  store [256][32];
        bit          written [256][32];
        bit          present [256];
        bit          used [256];
        logic [7:0]  last_slot;
        bit          last_valid;
        logic [13:0] emitted;
        int          rec_len;
        pick_t       picks_due [$];
        int          errors;
        int          checked;
        int          found_count;
        int          overlap_count;

        function new();
            rec_len = 1;
            errors = 0;
            checked = 0;
            found_count = 0;
            overlap_count = 0;
            clear_marks();
        endfunction

        function void clear_marks();
            for (int i = 0; i < 256; i++)
            begin
                present[i] = 0;
                used[i] = 0;
            end
            last_slot = 0;
            last_valid = 0;
            emitted = 0;
        endfunction

        function void set_len(logic [5:0] v);
            rec_len = (v == 0) ? 1 : (v > 32) ? 32 : int'(v);
        endfunction

        function bit tail_match(int a, int b, int len);
            for (int k = 0; k < len; k++)
                if (store[a][rec_len - len + k] != store[b][k])
                    return 0;
            return 1;
        endfunction

        function void note_input(cmd_t cmd, logic [7:0] slot, logic [4:0] pos,
                                 logic [7:0] value);
            int    best;
            int    best_ov;
            bit    have;
            pick_t p;
            best = 0;
            best_ov = 0;
            have = 0;
            case (cmd)
                CMD_LOAD:
                begin
                    store[slot][pos] = value;
                    written[slot][pos] = 1;
                    present[slot] = 1;
                end
                CMD_CLEAR: clear_marks();
                CMD_NEXT:
                begin
                    for (int i = 0; i < 256; i++)
                    begin
                        if (!present[i] || used[i])
                            continue;
                        if (best_ov == 0)
                        begin
                            best = i;
                            have = 1;
                        end
                        if (last_valid)
                            for (int ov = rec_len; ov > best_ov; ov--)
                                if (tail_match(last_slot, i, ov))
                                begin
                                    best = i;
                                    best_ov = ov;
                                    break;
                                end
                    end
                    p = '0;
                    if (have)
                    begin
                        p.found = 1;
                        p.slot = best[7:0];
                        p.place = 13'(emitted - best_ov);
                        p.overlap = best_ov[5:0];
                        emitted = 14'(emitted + rec_len - best_ov);
                        used[best] = 1;
                        last_slot = best[7:0];
                        last_valid = 1;
                    end
                    picks_due.push_back(p);
                end
                default: ;
            endcase
        endfunction

        function void check(logic found, logic [31:0] data);
            pick_t e;
            checked++;
            if (picks_due.size() == 0)
            begin
                $error("pick transaction with none expected");
                errors++;
                return;
            end
            e = picks_due.pop_front();
            if (e.found) found_count++;
            if (e.overlap != 0) overlap_count++;
            if (found !== e.found)
            begin
                $error("found: expected %0d actual %0d", e.found, found);
                errors++;
            end
            if (data[7:0] !== e.slot)
            begin
                $error("picked_slot: expected %0d actual %0d", e.slot, data[7:0]);
                errors++;
            end
            if (data[20:8] !== e.place)
            begin
                $error("place: expected %0d actual %0d", e.place, data[20:8]);
                errors++;
            end
            if (data[26:21] !== e.overlap)
            begin
                $error("overlap_len: expected %0d actual %0d", e.overlap, data[26:21]);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;

    merge_order_scoreboard sb;
    bit    hold_req;
    bit    no_idle;
    int    items_sent;
    int    cycles;

    greedy_overlap_merge_order dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 10000000)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 35) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one transaction on the command stream
    task automatic send(cmd_t cmd, logic [7:0] slot, logic [4:0] pos, logic [7:0] value);
        int g;
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {3'b000, value, pos, slot};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(cmd, slot, pos, value);
        if (cmd != CMD_NOP)
            items_sent++;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.picks_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_len(logic [5:0] v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_len(v);
    endtask

    function automatic logic [7:0] rand_byte(bit narrow);
        return narrow ? 8'($urandom_range(0, 1)) : 8'($urandom);
    endfunction

    task automatic load_record(logic [7:0] slot, bit narrow);
        for (int p = 0; p < sb.rec_len; p++)
            send(CMD_LOAD, slot, 5'(p), rand_byte(narrow));
    endtask

    // every byte a pick may compare must have been loaded
    task automatic fill_missing();
        for (int s = 0; s < 256; s++)
            if ((sb.present[s] && !sb.used[s]) || (sb.last_valid && sb.last_slot == s))
                for (int p = 0; p < sb.rec_len; p++)
                    if (!sb.written[s][p])
                        send(CMD_LOAD, 8'(s), 5'(p), rand_byte(1));
    endtask

    task automatic pick();
        fill_missing();
        send(CMD_NEXT, 8'($urandom), 5'($urandom), 8'($urandom));
    endtask

    function automatic int live_count();
        int n;
        n = 0;
        for (int s = 0; s < 256; s++)
            if (sb.present[s] && !sb.used[s]) n++;
        return n;
    endfunction

    initial
    begin
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 0;
                repeat (3000) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 3) != 0);
                @(posedge clk);
                if (m_tvalid && m_tready)
                    sb.check(m_tuser, m_tdata);
            end
        end
    end

    initial
    begin
        int lens [8] = '{2, 63, 0, 3, 1, 4, 2, 5};
        int r;
        int ph_start;
        sb = new();
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = CMD_NOP;
        cfg_we = 0;
        cfg_wdata = '0;
        hold_req = 0;
        no_idle = 0;
        items_sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty pick, extremes, nop command, clear
        send(CMD_NEXT, 8'h00, 5'h00, 8'h00);
        write_len(6'd2);
        send(CMD_LOAD, 8'hFF, 5'd0, 8'hFF);
        send(CMD_LOAD, 8'hFF, 5'd1, 8'hFF);
        send(CMD_LOAD, 8'h00, 5'd0, 8'hFF);
        send(CMD_LOAD, 8'h00, 5'd1, 8'h00);
        send(CMD_LOAD, 8'h55, 5'd31, 8'h00);
        send(CMD_LOAD, 8'h55, 5'd0, 8'h00);
        send(CMD_LOAD, 8'h55, 5'd1, 8'hAA);
        send(CMD_NOP, 8'hFF, 5'd31, 8'hFF);
        pick();
        pick();
        pick();
        pick();
        send(CMD_CLEAR, 8'h00, 5'd0, 8'h00);
        pick();
        send(CMD_LOAD, 8'hAA, 5'd0, 8'h0F);
        pick();
        pick();

        // receiver holds off while picks pile up
        send(CMD_CLEAR, 8'h00, 5'd0, 8'h00);
        for (int i = 0; i < 5; i++)
            load_record(8'($urandom_range(0, 255)), 1);
        drain();
        hold_req = 1;
        for (int i = 0; i < 5; i++)
            pick();
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            write_len(6'(lens[ph]));
            no_idle = (ph == 5);
            send(CMD_CLEAR, 8'h00, 5'd0, 8'h00);
            ph_start = items_sent;
            while (items_sent - ph_start < 8)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    if (live_count() >= 8)
                        send(CMD_CLEAR, 8'h00, 5'd0, 8'h00);
                    load_record(8'($urandom), $urandom_range(0, 3) != 0);
                end
                else if (r < 85)
                    pick();
                else if (r < 90)
                    send(CMD_CLEAR, 8'h00, 5'd0, 8'h00);
                else if (r < 94)
                    send(CMD_NOP, 8'($urandom), 5'($urandom), 8'($urandom));
                else
                    send(CMD_LOAD, 8'($urandom), 5'($urandom), 8'($urandom));
            end
            pick();
            if (ph == 3)
                drain();
        end

        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d command transactions, %0d picks checked", items_sent,
                 sb.checked);
        $display("%0d picks found a record, %0d with overlap", sb.found_count,
                 sb.overlap_count);
        if (sb.errors == 0 && sb.picks_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+src
src/gomo_pkg.sv
src/greedy_overlap_merge_order.sv
test/greedy_overlap_merge_order_test.sv
